>>> design/taylor_trig_unit_macros.svh
// assertion macros for the trig unit
// used by taylor_trig_unit.sv, no other dependencies
`ifndef TAYLOR_TRIG_UNIT_MACROS_SVH
`define TAYLOR_TRIG_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define TTU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define TTU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/ttu_pkg.sv
// shared types, constants and helper functions of the trig unit
// no dependencies
package ttu_pkg;

    localparam logic [63:0] HALF_PI_Q32 = 64'd6746518852;
    localparam logic [63:0] INT_LIM     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [47:0] OUT_MAX     = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] OUT_MIN     = 48'h8000_0000_0001;
    localparam int          DVD_W       = 79;
    localparam int          DSR_W       = 48;

    typedef enum logic [1:0] {
        CMD_SIN = 2'd0,
        CMD_COS = 2'd1,
        CMD_TAN = 2'd2,
        CMD_COT = 2'd3
    } cmd_t;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;
    localparam logic [1:0] ST_CAP = 2'd3;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic        sat;
        logic [63:0] res;
    } mul_rsp_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quo;
        logic [DSR_W-1:0] rem;
    } div_rsp_t;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        logic [63:0] r;
        r = v[63] ? (~v + 64'd1) : v;
        return r;
    endfunction

    // saturating signed add, msb of result is the clamp flag
    function automatic logic [64:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s > $signed({1'b0, INT_LIM}))
            return {1'b1, INT_LIM};
        else if (s < -$signed({1'b0, INT_LIM}))
            return {1'b1, ~INT_LIM + 64'd1};
        return {1'b0, s[63:0]};
    endfunction

    // clamp to the 48-bit output range, msb of result is the clamp flag
    function automatic logic [48:0] clamp48(input logic [63:0] v);
        logic signed [63:0] sv;
        sv = $signed(v);
        if (sv > $signed({16'd0, OUT_MAX}))
            return {1'b1, OUT_MAX};
        else if (sv < -$signed({16'd0, OUT_MAX}))
            return {1'b1, OUT_MIN};
        return {1'b0, v[47:0]};
    endfunction

endpackage

>>> design/ttu_mul.sv
// q32 magnitude multiplier: 64x64 product from four 32x32 partial products,
// rounded at bit 31 and clamped to 2^63-1; uses ttu_pkg
module ttu_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  ttu_pkg::mul_req_t req,
    output ttu_pkg::mul_rsp_t rsp
);
    import ttu_pkg::*;

    logic         busy_reg;
    logic [2:0]   cnt_reg;
    logic         pvld_reg;
    logic [1:0]   pidx_reg;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [63:0]  pp_reg;
    logic [127:0] acc_reg;
    logic [31:0]  opa;
    logic [31:0]  opb;
    logic [127:0] pp_shifted;
    logic [127:0] rnd;
    logic         sat;

    assign opa = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign opb = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];

    always_comb
    begin
        case (pidx_reg)
            2'd0:    pp_shifted = {64'd0, pp_reg};
            2'd3:    pp_shifted = {pp_reg, 64'd0};
            default: pp_shifted = {32'd0, pp_reg, 32'd0};
        endcase
    end

    assign rnd = acc_reg + 128'h8000_0000;
    assign sat = |rnd[127:95];

    assign rsp.done = busy_reg && (cnt_reg == 3'd5);
    assign rsp.sat  = sat;
    assign rsp.res  = sat ? INT_LIM : rnd[95:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
            pvld_reg <= 1'b0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 3'd0;
            pvld_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            pvld_reg <= (cnt_reg < 3'd4);
            cnt_reg  <= cnt_reg + 3'd1;
            if (cnt_reg == 3'd5)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= 128'd0;
        end
        else if (busy_reg)
        begin
            pp_reg   <= 64'(opa) * 64'(opb);
            pidx_reg <= cnt_reg[1:0];
            if (pvld_reg)
                acc_reg <= acc_reg + pp_shifted;
        end
    end

endmodule

>>> design/ttu_div.sv
// restoring divider, one quotient bit per cycle over 79 dividend bits
// uses ttu_pkg
module ttu_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ttu_pkg::div_req_t req,
    output ttu_pkg::div_rsp_t rsp
);
    import ttu_pkg::*;

    logic             busy_reg;
    logic [6:0]       cnt_reg;
    logic [DVD_W-1:0] num_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, num_reg[DVD_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    assign rsp.done = busy_reg && (cnt_reg == 7'd0);
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 7'(DVD_W);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 7'd0)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.dividend;
            dsr_reg <= req.divisor;
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (busy_reg && (cnt_reg != 7'd0))
        begin
            num_reg <= {num_reg[DVD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
        end
    end

endmodule

>>> design/taylor_trig_unit.sv
// taylor series sine/cosine/tangent/cotangent unit, one word at a time
// each series term is a check, a multiply and a divide on the shared divider, with
// setup, x*x and wrap-up per series, up to MAX_TERMS terms; tangent and cotangent
// run two series and one more divide; a new word is taken after the last one leaves
// the sequencer. reset is async active low: tolerance returns to 43 and the
// sequencer and output register go empty
module taylor_trig_unit #(
    parameter int MAX_TERMS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] angle
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [47:0] value, [55:48] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import ttu_pkg::*;
    `include "taylor_trig_unit_macros.svh"

    localparam int N_W = $clog2(MAX_TERMS + 1);
    localparam int K_W = $clog2(2 * MAX_TERMS + 4);
    localparam int D_W = 2 * K_W;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_INIT  = 10'b00_0000_0010,
        S_X2    = 10'b00_0000_0100,
        S_CHECK = 10'b00_0000_1000,
        S_MUL   = 10'b00_0001_0000,
        S_DIV   = 10'b00_0010_0000,
        S_END   = 10'b00_0100_0000,
        S_QDIV  = 10'b00_1000_0000,
        S_QWAIT = 10'b01_0000_0000,
        S_FIN   = 10'b10_0000_0000
    } state_t;

    state_t       state_reg;
    cmd_t         cmd_reg;
    logic         ser_reg;
    logic [63:0]  x0_reg;
    logic [63:0]  x2_reg;
    logic [63:0]  term_reg;
    logic [63:0]  sum_reg;
    logic [N_W-1:0] n_reg;
    logic [K_W-1:0] k_reg;
    logic [D_W-1:0] d_reg;
    logic [47:0]  s_reg;
    logic [47:0]  c_reg;
    logic [47:0]  val_reg;
    logic         sat_reg;
    logic         cap_reg;
    logic         dz_reg;
    logic         neg_reg;
    logic [31:0]  tol_reg;
    logic         m_vld_reg;
    logic [47:0]  m_val_reg;
    logic [1:0]   m_st_reg;

    mul_req_t     mreq;
    mul_rsp_t     mrsp;
    div_req_t     dreq;
    div_rsp_t     drsp;

    logic         accept;
    logic         cfg_wr;
    logic         two_series;
    logic [63:0]  xsel;
    logic [63:0]  term_mag;
    logic         stop;
    logic         cap_hit;
    logic         go;
    logic [64:0]  sum_next;
    logic [48:0]  clamped;
    logic [47:0]  num;
    logic [47:0]  den;
    logic [63:0]  num_mag;
    logic [63:0]  den_mag;
    logic [63:0]  q_term;
    logic [47:0]  qv;
    logic         q_sat;
    logic         out_free;
    logic         out_dz;
    logic         out_full_scale;

    ttu_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
    ttu_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == 1'b0) ? tol_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= 32'd43;
        else if (cfg_wr && (paddr[2] == 1'b0))
            tol_reg <= pwdata;
    end

    // datapath decode
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign two_series    = (cmd_reg == CMD_TAN) || (cmd_reg == CMD_COT);
    assign xsel          = ser_reg ? (x0_reg + HALF_PI_Q32) : x0_reg;
    assign term_mag      = mag64(term_reg);
    assign stop          = term_mag <= {32'd0, tol_reg};
    assign cap_hit       = n_reg >= N_W'(MAX_TERMS);
    assign go            = (state_reg == S_CHECK) && !stop && !cap_hit;
    assign sum_next      = add_sat(sum_reg, term_reg);
    assign clamped       = clamp48(sum_reg);
    assign num           = (cmd_reg == CMD_TAN) ? s_reg : c_reg;
    assign den           = (cmd_reg == CMD_TAN) ? c_reg : s_reg;
    assign num_mag       = mag64({{16{num[47]}}, num});
    assign den_mag       = mag64({{16{den[47]}}, den});
    assign q_term        = drsp.quo[63:0];
    assign out_free      = !m_vld_reg || m_axis_tready;

    // rounding and clamping of the final quotient
    always_comb
    begin
        q_sat = 1'b0;
        qv    = {1'b0, drsp.quo[46:0]};
        if (|drsp.quo[78:47])
        begin
            q_sat = 1'b1;
            qv    = OUT_MAX;
        end
        else if ({drsp.rem, 1'b0} >= {1'b0, den_mag[47:0]})
        begin
            if (&drsp.quo[46:0])
            begin
                q_sat = 1'b1;
                qv    = OUT_MAX;
            end
            else
                qv = {1'b0, drsp.quo[46:0]} + 48'd1;
        end
    end

    always_comb
    begin
        mreq.start = (state_reg == S_INIT) || go;
        mreq.a     = (state_reg == S_INIT) ? mag64(xsel) : term_mag;
        mreq.b     = (state_reg == S_INIT) ? mag64(xsel) : x2_reg;
    end

    always_comb
    begin
        dreq.start    = ((state_reg == S_MUL) && mrsp.done) ||
                        ((state_reg == S_QDIV) && (den != 48'd0));
        dreq.dividend = (state_reg == S_QDIV) ? {num_mag[46:0], 32'd0} :
                        {15'd0, mrsp.res + 64'(d_reg[D_W-1:1])};
        dreq.divisor  = (state_reg == S_QDIV) ? den_mag[47:0] : 48'(d_reg);
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
        begin
            unique case (state_reg)
                S_IDLE:  if (accept) state_reg <= S_INIT;
                S_INIT:  state_reg <= S_X2;
                S_X2:    if (mrsp.done) state_reg <= S_CHECK;
                S_CHECK: state_reg <= go ? S_MUL : S_END;
                S_MUL:   if (mrsp.done) state_reg <= S_DIV;
                S_DIV:   if (drsp.done) state_reg <= S_CHECK;
                S_END:
                begin
                    if (two_series && !ser_reg)
                        state_reg <= S_INIT;
                    else if (two_series)
                        state_reg <= S_QDIV;
                    else
                        state_reg <= S_FIN;
                end
                S_QDIV:  state_reg <= (den == 48'd0) ? S_FIN : S_QWAIT;
                S_QWAIT: if (drsp.done) state_reg <= S_FIN;
                S_FIN:   if (out_free) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg <= 1'b0;
            cap_reg <= 1'b0;
            dz_reg  <= 1'b0;
        end
        else if (accept)
        begin
            sat_reg <= 1'b0;
            cap_reg <= 1'b0;
            dz_reg  <= 1'b0;
        end
        else
        begin
            if (((state_reg == S_X2) || (state_reg == S_MUL)) && mrsp.done && mrsp.sat)
                sat_reg <= 1'b1;
            if (go && sum_next[64])
                sat_reg <= 1'b1;
            if ((state_reg == S_END) && clamped[48])
                sat_reg <= 1'b1;
            if ((state_reg == S_QWAIT) && drsp.done && q_sat)
                sat_reg <= 1'b1;
            if ((state_reg == S_CHECK) && !stop && cap_hit)
                cap_reg <= 1'b1;
            if ((state_reg == S_QDIV) && (den == 48'd0))
                dz_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_reg <= cmd_t'(s_axis_tuser);
                    ser_reg <= (cmd_t'(s_axis_tuser) == CMD_COS);
                    x0_reg  <= {{28{s_axis_tdata[31]}}, s_axis_tdata, 4'd0};
                end
            end
            S_INIT:
            begin
                term_reg <= xsel;
                sum_reg  <= 64'd0;
                n_reg    <= '0;
                k_reg    <= K_W'(1);
                d_reg    <= D_W'(6);
            end
            S_X2:
            begin
                if (mrsp.done)
                    x2_reg <= mrsp.res;
            end
            S_CHECK:
            begin
                if (go)
                begin
                    sum_reg <= sum_next[63:0];
                    n_reg   <= n_reg + N_W'(1);
                end
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    term_reg <= term_reg[63] ? q_term : (~q_term + 64'd1);
                    k_reg    <= k_reg + K_W'(2);
                    // (k+3)(k+4) = (k+1)(k+2) + 4k + 10
                    d_reg    <= d_reg + D_W'({k_reg, 2'b00}) + D_W'(10);
                end
            end
            S_END:
            begin
                if (!ser_reg)
                    s_reg <= clamped[47:0];
                else
                    c_reg <= clamped[47:0];
                val_reg <= clamped[47:0];
                if (two_series && !ser_reg)
                    ser_reg <= 1'b1;
            end
            S_QDIV:
            begin
                neg_reg <= num[47] ^ den[47];
                if (den == 48'd0)
                    val_reg <= num[47] ? OUT_MIN : OUT_MAX;
            end
            S_QWAIT:
            begin
                if (drsp.done)
                    val_reg <= neg_reg ? (~qv + 48'd1) : qv;
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else if ((state_reg == S_FIN) && out_free)
            m_vld_reg <= 1'b1;
        else if (m_axis_tready)
            m_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_FIN) && out_free)
        begin
            m_val_reg <= val_reg;
            m_st_reg  <= dz_reg ? ST_DZ : cap_reg ? ST_CAP : sat_reg ? ST_SAT : ST_OK;
        end
    end

    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tdata  = {8'd0, m_val_reg};
    assign m_axis_tuser  = m_st_reg;

    assign out_dz         = m_axis_tvalid && (m_axis_tuser == ST_DZ);
    assign out_full_scale = (m_axis_tdata[47:0] == OUT_MAX) || (m_axis_tdata[47:0] == OUT_MIN);

    // a taken word keeps the input closed until its result is formed
    `TTU_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, !s_axis_tready)

    // the shared multiplier and divider never run at once
    `TTU_ASSERT_NOW(a_units_exclusive, clk, rst_n, mrsp.done, !drsp.done)

    // division by zero always reports a full-scale value
    `TTU_ASSERT_NOW(a_dz_full_scale, clk, rst_n, out_dz, out_full_scale)

endmodule

>>> verif/testbench.sv
// self-checking testbench for the taylor series trig unit
// predicts each result from its own fixed-point series model and compares words
// depends on ttu_pkg and taylor_trig_unit
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ttu_pkg::*;

    localparam int          N_TERMS  = 32;
    localparam logic [63:0] LIM63    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIM47    = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [31:0] TOL_RST  = 32'd43;
    localparam logic [2:0]  ADDR_TOL = 3'd0;
    localparam logic [31:0] PI_Q28   = 32'd843314857;
    localparam logic [31:0] HPI_Q28  = 32'd421657428;

    typedef struct {
        logic [47:0] value;
        logic [1:0]  status;
    } trig_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        s_axis_tvalid, s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] angle
    logic [1:0]  s_axis_tuser;   // [1:0] cmd
    logic        m_axis_tvalid, m_axis_tready;
    logic [55:0] m_axis_tdata;   // [47:0] value, [55:48] zero
    logic [1:0]  m_axis_tuser;   // [1:0] status

    taylor_trig_unit #(.MAX_TERMS(N_TERMS)) dut (.*);

    trig_result_t pending_results[$];
    logic [31:0]  tol_q;
    bit           flag_sat, flag_cap;
    int           n_errors, n_sent, n_checked;
    int           n_st_sat, n_st_dz, n_st_cap;
    int           idle_pct, stall_pct, hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #400ms;
        $display("timeout after %0d results", n_checked);
        $display("testbench NOT OK");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic logic [63:0] abs64(input logic [63:0] v);
        return v[63] ? (~v + 64'd1) : v;
    endfunction

    // rounded q32 product of magnitudes, clamps at 2^63-1
    function automatic logic [63:0] mul_q32_round(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] pr;
        logic [96:0]  r;
        pr = {64'd0, a} * {64'd0, b};
        r = {1'b0, pr[127:32]} + 97'(pr[31]);
        if (r > {33'd0, LIM63})
        begin
            flag_sat = 1'b1;
            return LIM63;
        end
        return r[63:0];
    endfunction

    function automatic logic [63:0] sine_sum(input logic [63:0] x);
        logic [63:0]        x2, p, d, q, k, term, sum;
        logic signed [64:0] wide;
        int                 n;
        x2 = mul_q32_round(abs64(x), abs64(x));
        term = x;
        sum = 64'd0;
        k = 64'd1;
        n = 0;
        while (abs64(term) > {32'd0, tol_q})
        begin
            if (n >= N_TERMS)
            begin
                flag_cap = 1'b1;
                break;
            end
            wide = $signed({sum[63], sum}) + $signed({term[63], term});
            if (wide > $signed({1'b0, LIM63}))
            begin
                flag_sat = 1'b1;
                sum = LIM63;
            end
            else if (wide < -$signed({1'b0, LIM63}))
            begin
                flag_sat = 1'b1;
                sum = ~LIM63 + 64'd1;
            end
            else
                sum = wide[63:0];
            n++;
            p = mul_q32_round(abs64(term), x2);
            d = (k + 64'd1) * (k + 64'd2);
            q = (p + d / 2) / d;
            term = term[63] ? q : (~q + 64'd1);
            k += 64'd2;
        end
        if ($signed(sum) > $signed(LIM47))
        begin
            flag_sat = 1'b1;
            sum = LIM47;
        end
        else if ($signed(sum) < -$signed(LIM47))
        begin
            flag_sat = 1'b1;
            sum = ~LIM47 + 64'd1;
        end
        return sum;
    endfunction

    function automatic logic [63:0] quotient_q32(input logic [63:0] num, input logic [63:0] den);
        logic [127:0] dvd, quo, rem, b;
        logic [63:0]  q;
        b = {64'd0, abs64(den)};
        dvd = {32'd0, abs64(num), 32'd0};
        quo = dvd / b;
        rem = dvd % b;
        if (quo > {64'd0, LIM47})
        begin
            flag_sat = 1'b1;
            q = LIM47;
        end
        else
        begin
            q = quo[63:0];
            if (rem != 0 && rem >= b - rem)
                q++;
            if (q > LIM47)
            begin
                flag_sat = 1'b1;
                q = LIM47;
            end
        end
        return (num[63] != den[63]) ? (~q + 64'd1) : q;
    endfunction

    function automatic trig_result_t predict_trig(input cmd_t cmd, input logic [31:0] angle);
        trig_result_t res;
        logic [63:0]  x, s, c, num, den, v;
        bit           dz;
        flag_sat = 1'b0;
        flag_cap = 1'b0;
        dz = 1'b0;
        s = 64'd0;
        c = 64'd0;
        x = {{28{angle[31]}}, angle, 4'd0};
        if (cmd != CMD_COS)
            s = sine_sum(x);
        if (cmd != CMD_SIN)
            c = sine_sum(x + HALF_PI_Q32);
        if (cmd == CMD_SIN)
            v = s;
        else if (cmd == CMD_COS)
            v = c;
        else
        begin
            num = (cmd == CMD_TAN) ? s : c;
            den = (cmd == CMD_TAN) ? c : s;
            if (den == 64'd0)
            begin
                dz = 1'b1;
                v = num[63] ? (~LIM47 + 64'd1) : LIM47;
            end
            else
                v = quotient_q32(num, den);
        end
        res.value = v[47:0];
        res.status = dz ? ST_DZ : flag_cap ? ST_CAP : flag_sat ? ST_SAT : ST_OK;
        return res;
    endfunction

    // ---------------- result checking ----------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        n_errors++;
    endtask

    always @(posedge clk)
    begin
        trig_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected word", 64'(m_axis_tdata), 64'd0);
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[47:0] !== want.value)
                    report_mismatch("value", 64'(m_axis_tdata[47:0]), 64'(want.value));
                if (m_axis_tdata[55:48] !== 8'd0)
                    report_mismatch("tdata padding", 64'(m_axis_tdata[55:48]), 64'd0);
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
            end
            n_checked++;
            if (m_axis_tuser == ST_SAT) n_st_sat++;
            if (m_axis_tuser == ST_DZ)  n_st_dz++;
            if (m_axis_tuser == ST_CAP) n_st_cap++;
        end
    end

    // receiver side: random stalls plus an optional long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_axis_tready = 1'b0;
                hold_cycles--;
            end
            else
                m_axis_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    // ---------------- stimulus ----------------
    task automatic send_word(input cmd_t cmd, input logic [31:0] angle);
        if ($urandom_range(99) < idle_pct)
            repeat ($urandom_range(1, 8)) @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = angle;
        s_axis_tuser = cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(predict_trig(cmd, angle));
        n_sent++;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_tolerance(input logic [31:0] val);
        wait_drained();
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = ADDR_TOL;
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        tol_q = val;
    endtask

    function automatic logic [31:0] random_angle();
        logic [31:0] k;
        case ($urandom_range(9)) inside
            [0:5]: return $urandom_range(32'h8000_0000) - 32'h4000_0000;
            [6:7]: return $urandom;
            8:
            begin
                k = $urandom_range(10) - 5;
                return k * HPI_Q28 + $urandom_range(128) - 64;
            end
            default: return $urandom_range(1024) - 512;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] corner[8];
        corner = '{32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF,
                   HPI_Q28, PI_Q28, -HPI_Q28};
        idle_pct = 0;
        stall_pct = 0;
        foreach (corner[i])
            for (int c = 0; c < 4; c++)
                if (i < 5 || c >= 2)
                    send_word(cmd_t'(c), corner[i]);
    endtask

    task automatic test_random(input int count);
        repeat (count) send_word(cmd_t'($urandom_range(3)), random_angle());
    endtask

    // the unit runs one word at a time, so it backs up quickly behind a stalled output
    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        @(negedge clk);
        hold_cycles = 30000;
        test_random(12);
        wait_drained();
        test_random(10);
    endtask

    task automatic test_tolerance_sweep();
        write_tolerance(32'd0);
        test_random(30);
        write_tolerance(32'hFFFF_FFFF);
        test_random(60);
        for (int i = 0; i < 4; i++)
        begin
            write_tolerance($urandom_range(32'h00FF_FFFF) >> $urandom_range(24));
            test_random(50);
        end
        write_tolerance(TOL_RST);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        tol_q = TOL_RST;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        write_tolerance(32'hFFFF_FFFF);
        test_directed();
        write_tolerance(TOL_RST);
        test_backpressure();

        idle_pct = 0;   stall_pct = 0;  test_random(490);
        idle_pct = 88;  stall_pct = 0;  test_random(300);
        idle_pct = 0;   stall_pct = 88; test_random(300);
        idle_pct = 28;  stall_pct = 28; test_random(300);
        test_tolerance_sweep();

        wait_drained();
        repeat (200) @(negedge clk);
        $display("sent %0d words, checked %0d results over tolerance 0, 43, max and random",
                 n_sent, n_checked);
        $display("statuses seen: saturated %0d, divide by zero %0d, term limit %0d",
                 n_st_sat, n_st_dz, n_st_cap);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/ttu_pkg.sv
design/ttu_mul.sv
design/ttu_div.sv
design/taylor_trig_unit.sv
verif/testbench.sv
